@@ design/sldw_pkg.sv @@
// Shared types, constants and segment table for the segment LCD digit writer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package sldw_pkg;

    localparam int NUM_DIGITS   = 4;
    localparam int SHADOW_DEPTH = NUM_DIGITS + 1;
    localparam int IDX_W        = $clog2(SHADOW_DEPTH);
    localparam int STEP_W       = $clog2(NUM_DIGITS);
    localparam int MODE_W       = 2;
    localparam int VALUE_W      = 14;
    localparam int POS_W        = 4;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 8;
    localparam int DIGIT_W      = 4;

    localparam logic [VALUE_W-1:0] MAX_NUMBER  = 14'd9999;
    localparam logic [VALUE_W-1:0] MAX_DIGIT   = 14'd9;
    localparam logic [VALUE_W-1:0] TOP_WEIGHT  = 14'd1000;
    localparam logic [POS_W-1:0]   MAX_DIG_POS = 4'd4;
    localparam logic [POS_W-1:0]   MAX_DOT_POS = 4'd3;
    localparam logic [DATA_W-1:0]  FLAG_BIT    = 8'h10;

    typedef enum logic [MODE_W-1:0] {
        MODE_NUMBER = 2'd0,
        MODE_DIGIT  = 2'd1,
        MODE_DOT    = 2'd2,
        MODE_COLON  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_DIGIT  = 2'd1,
        KIND_FLAG   = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [IDX_W-1:0]    idx;
        logic [VALUE_W-1:0]  value;
        logic                flag_on;
    } t_cmd;

    typedef struct packed {
        logic                accepted;
        logic                clear_all;
        logic                write_enable;
        logic [ADDR_W-1:0]   ram_address;
        logic [DATA_W-1:0]   ram_data;
        logic                last;
    } t_result;

    function automatic logic [DATA_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
        logic [DATA_W-1:0] code;
        case (d)
            4'd0:    code = 8'hEB;
            4'd1:    code = 8'h0A;
            4'd2:    code = 8'hAD;
            4'd3:    code = 8'h8F;
            4'd4:    code = 8'h4E;
            4'd5:    code = 8'hC7;
            4'd6:    code = 8'hE7;
            4'd7:    code = 8'h8A;
            4'd8:    code = 8'hEF;
            4'd9:    code = 8'hCF;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic [VALUE_W-1:0] digit_weight(input logic [DIGIT_W-1:0] q);
        logic [2*VALUE_W-1:0] prod;
        prod = {{(2*VALUE_W-DIGIT_W){1'b0}}, q} * {{VALUE_W{1'b0}}, TOP_WEIGHT};
        return prod[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/sldw_front.sv @@
// Front part: takes command items, checks operands and classifies them into queue entries.
// Depends on sldw_pkg.
`default_nettype none

module sldw_front (
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [sldw_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [sldw_pkg::VALUE_W-1:0]  i_value_in,
    input  wire logic [sldw_pkg::POS_W-1:0]    i_position,
    input  wire logic                          i_flag_on,
    input  wire logic                          i_full,
    output logic                               o_push,
    output sldw_pkg::t_cmd                     o_cmd
);

    sldw_pkg::t_mode mode;

    assign mode       = sldw_pkg::t_mode'(i_mode);
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_cmd.kind    = sldw_pkg::KIND_REJECT;
        o_cmd.idx     = '0;
        o_cmd.value   = i_value_in;
        o_cmd.flag_on = i_flag_on;
        case (mode)
            sldw_pkg::MODE_NUMBER: begin
                if (i_value_in <= sldw_pkg::MAX_NUMBER) begin
                    o_cmd.kind = sldw_pkg::KIND_NUMBER;
                end
            end
            sldw_pkg::MODE_DIGIT: begin
                if (i_position <= sldw_pkg::MAX_DIG_POS && i_value_in <= sldw_pkg::MAX_DIGIT) begin
                    o_cmd.kind = sldw_pkg::KIND_DIGIT;
                    o_cmd.idx  = i_position[sldw_pkg::IDX_W-1:0];
                end
            end
            sldw_pkg::MODE_DOT: begin
                if (i_position <= sldw_pkg::MAX_DOT_POS) begin
                    o_cmd.kind = sldw_pkg::KIND_FLAG;
                    o_cmd.idx  = i_position[sldw_pkg::IDX_W-1:0] + sldw_pkg::IDX_W'(1);
                end
            end
            sldw_pkg::MODE_COLON: begin
                o_cmd.kind = sldw_pkg::KIND_FLAG;
            end
            default: begin
                o_cmd.kind = sldw_pkg::KIND_REJECT;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/sldw_queue.sv @@
// Short command queue between the front and back parts of the digit writer.
// Depends on sldw_pkg for the entry type.
`default_nettype none

module sldw_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  sldw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_valid,
    output sldw_pkg::t_cmd o_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sldw_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/sldw_back.sv @@
// Back part: keeps the segment shadow, splits numbers into digits one per cycle while the
// result stage can take them, and drives the registered result stage. Depends on sldw_pkg.
`default_nettype none

module sldw_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  sldw_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output sldw_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DIGITS = 2'b10
    } t_back_state;

    t_back_state                     r_state, n_state;
    logic [sldw_pkg::STEP_W-1:0]     r_step, n_step;
    logic [sldw_pkg::VALUE_W-1:0]    r_rem, n_rem;
    logic [sldw_pkg::DATA_W-1:0]     r_shadow [sldw_pkg::SHADOW_DEPTH];
    logic                            r_out_valid, n_out_valid;
    sldw_pkg::t_result               r_out, n_out;

    logic                            can_emit;
    logic                            emit;
    logic                            sh_we;
    logic [sldw_pkg::IDX_W-1:0]      sh_idx;
    logic [sldw_pkg::DATA_W-1:0]     sh_data;
    logic [sldw_pkg::DIGIT_W-1:0]    q;
    logic [sldw_pkg::VALUE_W-1:0]    rem_low;
    logic [sldw_pkg::VALUE_W-1:0]    rem_next;
    logic [sldw_pkg::DATA_W-1:0]     head_entry;
    sldw_pkg::t_result               res;

    assign can_emit    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign head_entry  = r_shadow[i_cmd.idx];

    // The leading digit is the number of thousand multiples that fit in the remainder.
    always_comb begin
        q = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_rem >= sldw_pkg::digit_weight(sldw_pkg::DIGIT_W'(k))) begin
                q = sldw_pkg::DIGIT_W'(k);
            end
        end
        rem_low  = r_rem - sldw_pkg::digit_weight(q);
        rem_next = (rem_low << 3) + (rem_low << 1);
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        emit    = 1'b0;
        o_pop   = 1'b0;
        sh_we   = 1'b0;
        sh_idx  = i_cmd.idx;
        sh_data = '0;
        res     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && can_emit) begin
                    o_pop = 1'b1;
                    emit  = 1'b1;
                    case (i_cmd.kind)
                        sldw_pkg::KIND_NUMBER: begin
                            res.accepted  = 1'b1;
                            res.clear_all = 1'b1;
                            n_state       = ST_DIGITS;
                            n_step        = '0;
                            n_rem         = i_cmd.value;
                        end
                        sldw_pkg::KIND_DIGIT: begin
                            sh_we   = 1'b1;
                            sh_data = (head_entry & sldw_pkg::FLAG_BIT)
                                    | sldw_pkg::digit_code(i_cmd.value[sldw_pkg::DIGIT_W-1:0]);
                            res.accepted     = 1'b1;
                            res.write_enable = 1'b1;
                            res.ram_address  = sldw_pkg::ADDR_W'({i_cmd.idx, 1'b0});
                            res.ram_data     = sh_data;
                            res.last         = 1'b1;
                        end
                        sldw_pkg::KIND_FLAG: begin
                            sh_we   = 1'b1;
                            sh_data = i_cmd.flag_on ? (head_entry | sldw_pkg::FLAG_BIT)
                                                    : (head_entry & ~sldw_pkg::FLAG_BIT);
                            res.accepted     = 1'b1;
                            res.write_enable = 1'b1;
                            res.ram_address  = sldw_pkg::ADDR_W'({i_cmd.idx, 1'b0});
                            res.ram_data     = sh_data;
                            res.last         = 1'b1;
                        end
                        default: begin
                            res.last = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIGITS: begin
                if (can_emit) begin
                    emit             = 1'b1;
                    sh_we            = 1'b1;
                    sh_idx           = sldw_pkg::IDX_W'(r_step);
                    sh_data          = sldw_pkg::digit_code(q);
                    res.accepted     = 1'b1;
                    res.write_enable = 1'b1;
                    res.ram_address  = sldw_pkg::ADDR_W'({r_step, 1'b0});
                    res.ram_data     = sh_data;
                    res.last         = (r_step == sldw_pkg::STEP_W'(sldw_pkg::NUM_DIGITS - 1));
                    n_rem            = rem_next;
                    n_step           = r_step + sldw_pkg::STEP_W'(1);
                    if (res.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sldw_pkg::SHADOW_DEPTH; i++) begin
                r_shadow[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (sh_we) begin
                r_shadow[sh_idx] <= sh_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

@@ design/segment_lcd_digit_writer_core.sv @@
// A command is first written into the queue; the back part then registers its result in the result stage.
// Results: each single-write or rejected command gives one result and each number command five,
// emitted by the back sequencer at one display RAM result per cycle while the output is not stalled.
// The front keeps accepting items while the command queue has room.
// Reset (synchronous, active low) empties the queue and result stage and zeroes the shadow.
// Depends on sldw_pkg, sldw_front, sldw_queue and sldw_back.
`default_nettype none

module segment_lcd_digit_writer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [sldw_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [sldw_pkg::VALUE_W-1:0]  i_value_in,
    input  wire logic [sldw_pkg::POS_W-1:0]    i_position,
    input  wire logic                          i_flag_on,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_accepted,
    output logic                               o_clear_all,
    output logic                               o_write_enable,
    output logic [sldw_pkg::ADDR_W-1:0]        o_ram_address,
    output logic [sldw_pkg::DATA_W-1:0]        o_ram_data,
    output logic                               o_last
);

    logic              push;
    logic              full;
    logic              pop;
    logic              head_valid;
    sldw_pkg::t_cmd    front_cmd;
    sldw_pkg::t_cmd    head_cmd;
    sldw_pkg::t_result result;

    sldw_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_value_in (i_value_in),
        .i_position (i_position),
        .i_flag_on  (i_flag_on),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    sldw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    sldw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_accepted     = result.accepted;
    assign o_clear_all    = result.clear_all;
    assign o_write_enable = result.write_enable;
    assign o_ram_address  = result.ram_address;
    assign o_ram_data     = result.ram_data;
    assign o_last         = result.last;

endmodule

`default_nettype wire

@@ design/sldw_checker.sv @@
// Port-level checks for the segment LCD digit writer, bound to the top level.
// Depends on sldw_pkg and segment_lcd_digit_writer_core.
`default_nettype none

module sldw_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_accepted,
    input wire logic                          o_clear_all,
    input wire logic                          o_write_enable,
    input wire logic [sldw_pkg::ADDR_W-1:0]   o_ram_address,
    input wire logic [sldw_pkg::DATA_W-1:0]   o_ram_data,
    input wire logic                          o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result valid dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_ram_data) && $stable(o_ram_address)
            && $stable(o_last) && $stable(o_accepted))
        else $error("Result payload changed while stalled.");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_last && !o_write_enable && !o_clear_all)
        else $error("Rejected command result is malformed.");

    a_clear_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clear_all |-> o_accepted && !o_write_enable && !o_last)
        else $error("Clear request must open a number sequence.");

    a_clear_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_clear_all |=> !o_out_valid
            || (o_write_enable && o_ram_address == '0))
        else $error("Clear request not followed by a write of the first digit.");

endmodule

bind segment_lcd_digit_writer_core sldw_checker u_sldw_checker (.*);

`default_nettype wire
